### sv/min_path_no_repeat_direction_macros.svh
// assertion macros for the min path block
// used by files that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef MIN_PATH_NO_REPEAT_DIRECTION_MACROS_SVH
`define MIN_PATH_NO_REPEAT_DIRECTION_MACROS_SVH

// check that is off while reset is asserted
`define MPNR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that also holds during reset
`define MPNR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/mpnr_pkg.sv
// shared types, constants and helpers for the min path block
// no dependencies
`timescale 1ns / 1ps

package mpnr_pkg;

  localparam int SUM_BITS         = 18;
  localparam int DEF_MAX_COLS     = 64;
  localparam int DEF_COST_BITS    = 8;
  localparam int ROWS_BITS        = 10;
  localparam int COLS_BITS        = 7;
  localparam int CFG_IDX_BITS     = 2;
  localparam int CFG_DATA_BITS    = 10;
  localparam int OUT_TDATA_BITS   = 24;

  localparam logic [SUM_BITS-1:0] SUM_INF = {SUM_BITS{1'b1}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS = 2'd1;

  localparam logic [ROWS_BITS-1:0] ROWS_RESET = 10'd6;
  localparam logic [COLS_BITS-1:0] COLS_RESET = 7'd6;

  typedef logic [SUM_BITS-1:0] sum_t;

  // path sums per arrival direction: upper right, above, upper left
  typedef struct packed {
    sum_t d0;
    sum_t d1;
    sum_t d2;
  } sums_t;

  // position flags handed to the cost unit
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
  } pos_t;

  localparam sums_t SUMS_INF = '{d0: SUM_INF, d1: SUM_INF, d2: SUM_INF};

  function automatic sum_t min2(input sum_t a, input sum_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

### sv/mpnr_cell.sv
// one column slot of the line store chain
// depends on mpnr_pkg
`timescale 1ns / 1ps

module mpnr_cell
  import mpnr_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  logic  insert_i,
  input  sums_t nbr_i,
  input  sums_t new_i,
  output sums_t sums_o
);

  sums_t sums_q;

  // take the neighbor's sums, or the fresh sums at the row's end slot
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sums_q <= insert_i ? new_i : nbr_i;
    end
  end

  assign sums_o = sums_q;

endmodule

### sv/mpnr_calc.sv
// per-cell path sum update: two-way minimum, saturating add
// depends on mpnr_pkg
`timescale 1ns / 1ps

module mpnr_calc
  import mpnr_pkg::*;
#(
  parameter int COST_BITS = DEF_COST_BITS
) (
  input  logic [COST_BITS-1:0] cost_i,
  input  pos_t                 pos_i,
  input  sums_t                above_i,
  input  sums_t                upright_i,
  input  sums_t                left_i,
  output sums_t                cur_o,
  output sum_t                 cur_min_o
);

  function automatic sum_t sat_add(input sum_t a, input logic [COST_BITS-1:0] c);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + (SUM_BITS+1)'(c);
    return s[SUM_BITS] ? SUM_INF : s[SUM_BITS-1:0];
  endfunction

  sum_t cost_ext;

  assign cost_ext = SUM_BITS'(cost_i);

  // first row starts every direction at the cost; moves from outside the grid are all ones
  always_comb begin
    if (pos_i.first_row) begin
      cur_o.d0 = cost_ext;
      cur_o.d1 = cost_ext;
      cur_o.d2 = cost_ext;
    end else begin
      cur_o.d0 = pos_i.last_col ? SUM_INF
                                : sat_add(min2(upright_i.d1, upright_i.d2), cost_i);
      cur_o.d1 = sat_add(min2(above_i.d0, above_i.d2), cost_i);
      cur_o.d2 = pos_i.first_col ? SUM_INF
                                 : sat_add(min2(left_i.d0, left_i.d1), cost_i);
    end
  end

  assign cur_min_o = min2(cur_o.d0, min2(cur_o.d1, cur_o.d2));

endmodule

### sv/min_path_no_repeat_direction.sv
// top level of the min path block: control, line store chain, result register
// depends on mpnr_pkg, mpnr_cell, mpnr_calc and the assertion macro header
`timescale 1ns / 1ps

// Grid minimum-cost path where no two consecutive moves share a direction.
// s_axis carries one cell cost per transfer in raster order, row by row.
// The grid size comes from the write port: index REG_ROWS sets rows, REG_COLS
// sets cols; any such write starts a new grid. Write only while idle.
// m_axis carries one result per grid: min_cost in tdata[17:0] and no_path in
// tdata[18]; all ones in min_cost means no path reaches the last row.
// Throughput is one cost per cycle when not stalled. The line store is a chain
// of MAX_COLS cells shifting one slot per accepted cost; the fresh sums enter at
// the slot of the last column in use, so slot 0 always holds the sums above.
// The result is registered and appears in the cycle after the last cost.
// A waiting result blocks only the last cost of the next grid; s_axis_tready
// drops when a result is held, m_axis_tready is low and the next cost would
// end a grid.
// Reset sets rows and cols to 6, clears counters and sets the running minimum
// to all ones; the line store is not cleared, it is always written before it is read.

module min_path_no_repeat_direction
  import mpnr_pkg::*;
#(
  parameter int MAX_COLS  = DEF_MAX_COLS,
  parameter int COST_BITS = DEF_COST_BITS,
  localparam int IN_TDATA_BITS = ((COST_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // cost stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // cost
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata   // min_cost, no_path, zero fill
);

  `include "min_path_no_repeat_direction_macros.svh"

  localparam int CW = $clog2(MAX_COLS);

  logic [ROWS_BITS-1:0] rows_q;
  logic [COLS_BITS-1:0] cols_q;
  logic [ROWS_BITS-1:0] row_q;
  logic [CW-1:0]        col_q;
  sum_t                 best_q;
  sums_t                left_q;
  logic                 out_valid_q;
  sum_t                 out_min_q;

  logic [ROWS_BITS-1:0] last_row;
  logic [CW-1:0]        last_col;
  logic                 s_fire;
  logic                 end_of_row;
  logic                 is_last_row;
  pos_t                 pos;
  sums_t                cur;
  sum_t                 cur_min;
  sum_t                 best_new;
  sums_t                cell_q [MAX_COLS];

  // effective grid bounds: zero counts as one, cols capped at the chain depth
  always_comb begin
    last_row = (rows_q == '0) ? '0 : rows_q - 10'd1;
    if (cols_q == '0) begin
      last_col = '0;
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(cols_q - 7'd1);
    end
  end

  // only the cost that ends a grid waits for the result register
  assign s_axis_tready = !out_valid_q || m_axis_tready || !(end_of_row && is_last_row);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign end_of_row    = (col_q == last_col);
  assign is_last_row   = (row_q == last_row);

  assign pos.first_row = (row_q == '0);
  assign pos.first_col = (col_q == '0);
  assign pos.last_col  = end_of_row;

  // cost unit
  mpnr_calc #(
    .COST_BITS (COST_BITS)
  ) u_calc (
    .cost_i    (s_axis_tdata[COST_BITS-1:0]),
    .pos_i     (pos),
    .above_i   (cell_q[0]),
    .upright_i (cell_q[1]),
    .left_i    (left_q),
    .cur_o     (cur),
    .cur_min_o (cur_min)
  );

  assign best_new = is_last_row ? min2(best_q, cur_min) : best_q;

  // line store chain, shifts toward slot 0
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    sums_t nbr;
    if (k == MAX_COLS - 1) begin : g_end
      assign nbr = cur;
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end
    mpnr_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (s_fire),
      .insert_i (last_col == CW'(k)),
      .nbr_i    (nbr),
      .new_i    (cur),
      .sums_o   (cell_q[k])
    );
  end

  // grid control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
      row_q  <= '0;
      col_q  <= '0;
      best_q <= SUM_INF;
      left_q <= SUMS_INF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROWS: begin
          rows_q <= cfg_wdata_i[ROWS_BITS-1:0];
          row_q  <= '0;
          col_q  <= '0;
          best_q <= SUM_INF;
          left_q <= SUMS_INF;
        end
        REG_COLS: begin
          cols_q <= cfg_wdata_i[COLS_BITS-1:0];
          row_q  <= '0;
          col_q  <= '0;
          best_q <= SUM_INF;
          left_q <= SUMS_INF;
        end
        default: begin
        end
      endcase
    end else if (s_fire) begin
      if (end_of_row) begin
        col_q  <= '0;
        left_q <= SUMS_INF;
        if (is_last_row) begin
          row_q  <= '0;
          best_q <= SUM_INF;
        end else begin
          row_q  <= row_q + 10'd1;
          best_q <= best_new;
        end
      end else begin
        col_q  <= col_q + 1'b1;
        left_q <= cell_q[0];
        best_q <= best_new;
      end
    end
  end

  // result register, refilled on the last cost of a grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire && end_of_row && is_last_row) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && end_of_row && is_last_row) begin
      out_min_q <= best_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS - SUM_BITS - 1){1'b0}},
                          (out_min_q == SUM_INF), out_min_q};

  // checks
  `MPNR_ASSERT(a_col_in_range, col_q <= last_col, "column counter beyond last column")
  `MPNR_ASSERT(a_result_from_input, $rose(out_valid_q) |-> $past(s_fire), "result without input")
  `MPNR_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> s_axis_tready, "input stalled while empty")

endmodule
